/* sv/rws_pkg.sv */
// ============================================================================
// rws_pkg
// Shared types and constants for the roulette wheel selection block.
// ============================================================================
`default_nettype none

package rws_pkg;

    localparam int MAX_ENTRIES   = 256;
    localparam int FITNESS_BITS  = 16;
    localparam int INDEX_BITS    = $clog2(MAX_ENTRIES);
    localparam int COUNT_BITS    = INDEX_BITS + 1;
    localparam int TOTAL_BITS    = 24;
    localparam int FRACTION_BITS = 16;
    localparam int TARGET_BITS   = FRACTION_BITS + TOTAL_BITS;
    localparam int PREFIX_BITS   = FITNESS_BITS + INDEX_BITS;

    localparam logic MODE_LOAD   = 1'b0;
    localparam logic MODE_SELECT = 1'b1;

    typedef enum logic [1:0] {
        STATUS_OK         = 2'd0,
        STATUS_ZERO_TOTAL = 2'd1,
        STATUS_EMPTY      = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MULT,
        ST_WALK,
        ST_FINISH
    } state_t;

    // Control from the sequencer to the prefix walk unit.
    typedef struct packed {
        logic load_target;
        logic clear_prefix;
        logic step;
    } walk_ctrl_t;

endpackage

`default_nettype wire

/* sv/rws_fitness_ram.sv */
// ============================================================================
// rws_fitness_ram
// Fitness table: one write port and one read port with registered read data.
// ============================================================================
`default_nettype none

module rws_fitness_ram
(
    input  wire logic                                  clk,
    input  wire logic                                  wr_en,
    input  wire logic [rws_pkg::INDEX_BITS-1:0]        wr_addr,
    input  wire logic [rws_pkg::FITNESS_BITS-1:0]      wr_data,
    input  wire logic [rws_pkg::INDEX_BITS-1:0]        rd_addr,
    output logic      [rws_pkg::FITNESS_BITS-1:0]      rd_data
);

    logic [rws_pkg::FITNESS_BITS-1:0] mem [rws_pkg::MAX_ENTRIES];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

/* sv/rws_prefix_walk.sv */
// ============================================================================
// rws_prefix_walk
// Target multiply and the shared prefix adder with its compare.
// ============================================================================
`default_nettype none

module rws_prefix_walk
(
    input  wire logic                                  clk,
    input  wire rws_pkg::walk_ctrl_t                   ctrl,
    input  wire logic [rws_pkg::FRACTION_BITS-1:0]     fraction,
    input  wire logic [rws_pkg::TOTAL_BITS-1:0]        total,
    input  wire logic [rws_pkg::FITNESS_BITS-1:0]      fitness,
    output logic                                       hit
);

    logic [rws_pkg::TARGET_BITS-1:0] target_reg;
    logic [rws_pkg::TARGET_BITS-1:0] target_next;
    logic [rws_pkg::PREFIX_BITS-1:0] prefix_reg;
    logic [rws_pkg::PREFIX_BITS-1:0] prefix_next;
    logic [rws_pkg::PREFIX_BITS-1:0] sum;
    logic [rws_pkg::TARGET_BITS-1:0] scaled_sum;

    assign target_next = rws_pkg::TARGET_BITS'(fraction) * rws_pkg::TARGET_BITS'(total);

    // Running prefix including the entry now on the read port.
    assign sum        = prefix_reg + rws_pkg::PREFIX_BITS'(fitness);
    assign scaled_sum = rws_pkg::TARGET_BITS'({sum, {rws_pkg::FRACTION_BITS{1'b0}}});
    assign hit        = (scaled_sum >= target_reg);

    always_comb
    begin
        prefix_next = prefix_reg;
        if (ctrl.clear_prefix)
        begin
            prefix_next = '0;
        end
        else if (ctrl.step)
        begin
            prefix_next = sum;
        end
    end

    always_ff @(posedge clk)
    begin
        prefix_reg <= prefix_next;
        if (ctrl.load_target)
        begin
            target_reg <= target_next;
        end
    end

endmodule

`default_nettype wire

/* sv/roulette_wheel_select.sv */
// ============================================================================
// roulette_wheel_select
// Fitness-proportionate selection over a table of stored fitness values.
// ============================================================================
// Usage: requests arrive on the in_* channel. A load request (mode 0) appends
// fitness_value to the table and adds it to a saturating running total; with
// first_entry set the table and total restart first. A load to a full table
// without first_entry is dropped. Loads give no result.
// A select request (mode 1) gives one result on the out_* channel: the
// 1-based index of the first entry whose prefix sum times 65536 reaches
// random_fraction times the total, or an error status with index 0 when the
// table is empty or the total is zero.
// A select with an error status goes straight to its result; a normal select
// first forms the target in ST_MULT, then walks the table from the first
// entry up to the chosen one. The walk reads one table entry per cycle from
// the single read port of the fitness memory and feeds it to one shared
// adder and comparator; that walk sets the throughput.
// The block takes no request while a select is being worked on. A finished
// result sits in the output register; while the receiver stalls, further
// loads and the next select are still accepted, and a second result waits
// inside the block until the output register frees up.
// Reset clears the entry count, the total and all handshake state; the
// table contents are left as they are; a walk only uses written entries.
// ============================================================================
`default_nettype none

module roulette_wheel_select
(
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  in_valid,
    output logic                                       in_ready,
    input  wire logic                                  mode,
    input  wire logic                                  first_entry,
    input  wire logic [15:0]                           fitness_value,
    input  wire logic [15:0]                           random_fraction,
    output logic                                       out_valid,
    input  wire logic                                  out_ready,
    output logic      [8:0]                            selected_index,
    output logic      [1:0]                            status
);

    rws_pkg::state_t state_reg;
    rws_pkg::state_t state_next;

    logic [rws_pkg::COUNT_BITS-1:0]   count_reg;
    logic [rws_pkg::COUNT_BITS-1:0]   count_next;
    logic [rws_pkg::TOTAL_BITS-1:0]   total_reg;
    logic [rws_pkg::TOTAL_BITS-1:0]   total_next;
    logic [rws_pkg::INDEX_BITS-1:0]   k_reg;
    logic [rws_pkg::INDEX_BITS-1:0]   k_next;
    logic [rws_pkg::FRACTION_BITS-1:0] frac_reg;
    logic [rws_pkg::FRACTION_BITS-1:0] frac_next;

    // Result waiting for the output register.
    logic [rws_pkg::COUNT_BITS-1:0]   res_index_reg;
    logic [rws_pkg::COUNT_BITS-1:0]   res_index_next;
    rws_pkg::status_t                 res_status_reg;
    rws_pkg::status_t                 res_status_next;

    logic                             out_valid_reg;
    logic                             out_valid_next;
    logic [rws_pkg::COUNT_BITS-1:0]   out_index_reg;
    logic [rws_pkg::COUNT_BITS-1:0]   out_index_next;
    rws_pkg::status_t                 out_status_reg;
    rws_pkg::status_t                 out_status_next;

    logic                             in_fire;
    logic                             load_fire;
    logic                             wr_en;
    logic [rws_pkg::INDEX_BITS-1:0]   wr_addr;
    logic [rws_pkg::INDEX_BITS-1:0]   rd_addr;
    logic [rws_pkg::FITNESS_BITS-1:0] rd_data;
    logic [rws_pkg::FITNESS_BITS-1:0] new_fitness;
    logic [rws_pkg::COUNT_BITS-1:0]   base_count;
    logic [rws_pkg::TOTAL_BITS-1:0]   base_total;
    logic [rws_pkg::TOTAL_BITS:0]     total_sum;
    logic                             last_entry;
    logic                             hit;
    logic                             publish;
    rws_pkg::walk_ctrl_t              walk_ctrl;

    assign in_ready  = (state_reg == rws_pkg::ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign load_fire = in_fire && (mode == rws_pkg::MODE_LOAD);

    // Load path: a first entry restarts the table before storing.
    assign new_fitness = fitness_value[rws_pkg::FITNESS_BITS-1:0];
    assign base_count  = first_entry ? '0 : count_reg;
    assign base_total  = first_entry ? '0 : total_reg;
    assign total_sum   = {1'b0, base_total} + (rws_pkg::TOTAL_BITS + 1)'(new_fitness);
    assign wr_en       = load_fire && (base_count < rws_pkg::COUNT_BITS'(rws_pkg::MAX_ENTRIES));
    assign wr_addr     = base_count[rws_pkg::INDEX_BITS-1:0];

    assign last_entry = ({1'b0, k_reg} == (count_reg - rws_pkg::COUNT_BITS'(1)));

    // The output register takes a new result when it is empty or being drained.
    assign publish = (state_reg == rws_pkg::ST_FINISH) && (!out_valid_reg || out_ready);

    rws_fitness_ram u_ram
    (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (new_fitness),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    rws_prefix_walk u_walk
    (
        .clk      (clk),
        .ctrl     (walk_ctrl),
        .fraction (frac_reg),
        .total    (total_reg),
        .fitness  (rd_data),
        .hit      (hit)
    );

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        total_next      = total_reg;
        k_next          = k_reg;
        frac_next       = frac_reg;
        res_index_next  = res_index_reg;
        res_status_next = res_status_reg;
        rd_addr         = k_reg + rws_pkg::INDEX_BITS'(1);
        walk_ctrl       = '0;

        unique case (state_reg)
            rws_pkg::ST_IDLE:
            begin
                if (load_fire)
                begin
                    count_next = base_count;
                    total_next = base_total;
                    if (wr_en)
                    begin
                        count_next = base_count + rws_pkg::COUNT_BITS'(1);
                        total_next = total_sum[rws_pkg::TOTAL_BITS]
                                   ? {rws_pkg::TOTAL_BITS{1'b1}}
                                   : total_sum[rws_pkg::TOTAL_BITS-1:0];
                    end
                end
                else if (in_fire)
                begin
                    frac_next = random_fraction[rws_pkg::FRACTION_BITS-1:0];
                    if (count_reg == '0)
                    begin
                        res_index_next  = '0;
                        res_status_next = rws_pkg::STATUS_EMPTY;
                        state_next      = rws_pkg::ST_FINISH;
                    end
                    else if (total_reg == '0)
                    begin
                        res_index_next  = '0;
                        res_status_next = rws_pkg::STATUS_ZERO_TOTAL;
                        state_next      = rws_pkg::ST_FINISH;
                    end
                    else
                    begin
                        state_next = rws_pkg::ST_MULT;
                    end
                end
            end

            rws_pkg::ST_MULT:
            begin
                // Form the target and start reading the first entry.
                walk_ctrl.load_target  = 1'b1;
                walk_ctrl.clear_prefix = 1'b1;
                rd_addr                = '0;
                k_next                 = '0;
                state_next             = rws_pkg::ST_WALK;
            end

            rws_pkg::ST_WALK:
            begin
                if (hit || last_entry)
                begin
                    res_index_next  = {1'b0, k_reg} + rws_pkg::COUNT_BITS'(1);
                    res_status_next = rws_pkg::STATUS_OK;
                    state_next      = rws_pkg::ST_FINISH;
                end
                else
                begin
                    walk_ctrl.step = 1'b1;
                    k_next         = k_reg + rws_pkg::INDEX_BITS'(1);
                end
            end

            rws_pkg::ST_FINISH:
            begin
                if (publish)
                begin
                    state_next = rws_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = rws_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next  = out_valid_reg && !out_ready;
        out_index_next  = out_index_reg;
        out_status_next = out_status_reg;
        if (publish)
        begin
            out_valid_next  = 1'b1;
            out_index_next  = res_index_reg;
            out_status_next = res_status_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rws_pkg::ST_IDLE;
            count_reg     <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg          <= k_next;
        frac_reg       <= frac_next;
        res_index_reg  <= res_index_next;
        res_status_reg <= res_status_next;
        out_index_reg  <= out_index_next;
        out_status_reg <= out_status_next;
    end

    assign out_valid      = out_valid_reg;
    assign selected_index = out_index_reg;
    assign status         = out_status_reg;

endmodule

`default_nettype wire
